### rtl/pcm_sample_to_float_core_macros.svh
// Assertion helpers for the core RTL file.
`ifndef PCM_SAMPLE_TO_FLOAT_CORE_MACROS_SVH
`define PCM_SAMPLE_TO_FLOAT_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PCM2F_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define PCM2F_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/pcm2f_pkg.sv
// ----------------------------------------------------------------------------
// pcm2f_pkg
// Shared types and codes for the PCM sample to float32 converter.
// ----------------------------------------------------------------------------
package pcm2f_pkg;

  localparam logic [1:0] WCODE_8  = 2'd0;
  localparam logic [1:0] WCODE_16 = 2'd1;
  localparam logic [1:0] WCODE_24 = 2'd2;
  localparam logic [1:0] WCODE_32 = 2'd3;

  localparam logic REG_IS_FLOAT = 1'b0;
  localparam logic REG_WIDTH    = 1'b1;

  localparam logic [1:0] WCODE_RESET = WCODE_16;

  typedef struct packed {
    logic       is_float;
    logic [1:0] width_code;
  } pcm2f_cfg_t;

endpackage

### rtl/pcm_sample_to_float_core.sv
// ----------------------------------------------------------------------------
// pcm_sample_to_float_core
// Raw little-endian PCM sample to normalized IEEE-754 single precision.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive in_raw_sample and pulse start; the item is taken at any edge
//   with start high, since busy stays low. One item may enter every cycle.
//   Output: out_strobe is high for one cycle with out_float_sample; the
//   receiver cannot stall, so each result must be taken in that cycle.
//   Pipeline: input register, then conversion into the result register.
//   Throughput: 1 item per cycle, set by the single-pass convert stage.
//   Config: APB registers at 0x0 (is_float_format) and 0x4
//   (sample_width_code). Write only while no item is in flight.
//   Reset: registers return to integer PCM, 16-bit; pipeline empties.
// ----------------------------------------------------------------------------
module pcm_sample_to_float_core
  import pcm2f_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_raw_sample,
  output logic        out_strobe,
  output logic [31:0] out_float_sample,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

`include "pcm_sample_to_float_core_macros.svh"

  pcm2f_cfg_t  cfg_r, cfg_nxt;
  logic        s1_valid_r;
  logic [31:0] s1_raw_r;
  logic        out_valid_r;
  logic [31:0] out_data_r;
  logic [31:0] conv_bits;
  logic        wr_en;

  assign busy   = 1'b0;
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (paddr[2])
        REG_IS_FLOAT: cfg_nxt.is_float   = pwdata[0];
        REG_WIDTH:    cfg_nxt.width_code = pwdata[1:0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_IS_FLOAT: prdata = {31'd0, cfg_r.is_float};
      REG_WIDTH:    prdata = {30'd0, cfg_r.width_code};
      default:      prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.is_float   <= 1'b0;
      cfg_r.width_code <= WCODE_RESET;
      s1_valid_r       <= 1'b0;
      out_valid_r      <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      s1_valid_r  <= start & ~busy;
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start & ~busy) s1_raw_r <= in_raw_sample;
    if (s1_valid_r)    out_data_r <= conv_bits;
  end

  pcm2f_conv u_conv (
    .cfg   (cfg_r),
    .raw   (s1_raw_r),
    .fbits (conv_bits)
  );

  assign out_strobe       = out_valid_r;
  assign out_float_sample = out_data_r;

  `PCM2F_ASSERT_NEXT(a_take_to_s1, start && !busy, s1_valid_r, "accepted item lost")
  `PCM2F_ASSERT_NEXT(a_s1_to_out, s1_valid_r, out_strobe, "stage 1 item not delivered")
  `PCM2F_ASSERT_IMPL(a_finite_out, out_strobe, out_float_sample[30:23] != 8'hFF,
                     "non-finite result")

endmodule

### rtl/pcm2f_conv.sv
// ----------------------------------------------------------------------------
// pcm2f_conv
// Combinational conversion of one raw sample word to a float32 bit pattern.
// ----------------------------------------------------------------------------
module pcm2f_conv
  import pcm2f_pkg::*;
(
  input  pcm2f_cfg_t  cfg,
  input  logic [31:0] raw,
  output logic [31:0] fbits
);

  always_comb begin
    logic [31:0] sv;
    logic [31:0] n;
    logic [4:0]  k;
    logic [4:0]  lz;
    logic        neg;
    logic        inc;
    logic [24:0] sum;
    logic [7:0]  expo;
    logic [22:0] frac;

    case (cfg.width_code)
      WCODE_8: begin
        // u - 128 is the low byte with its top bit flipped, read as signed
        sv = {{24{~raw[7]}}, ~raw[7], raw[6:0]};
        k  = 5'd7;
      end
      WCODE_16: begin
        sv = {{16{raw[15]}}, raw[15:0]};
        k  = 5'd15;
      end
      WCODE_24: begin
        sv = {{8{raw[23]}}, raw[23:0]};
        k  = 5'd23;
      end
      default: begin
        sv = raw;
        k  = 5'd31;
      end
    endcase

    neg = sv[31];
    n   = neg ? (~sv + 32'd1) : sv;

    // leading-zero normalize, binary steps
    lz = 5'd0;
    if (n[31:16] == 16'd0) begin n = {n[15:0], 16'd0}; lz[4] = 1'b1; end
    if (n[31:24] == 8'd0)  begin n = {n[23:0], 8'd0};  lz[3] = 1'b1; end
    if (n[31:28] == 4'd0)  begin n = {n[27:0], 4'd0};  lz[2] = 1'b1; end
    if (n[31:30] == 2'd0)  begin n = {n[29:0], 2'd0};  lz[1] = 1'b1; end
    if (n[31] == 1'b0)     begin n = {n[30:0], 1'b0};  lz[0] = 1'b1; end

    // round to nearest even on the dropped 8 bits
    inc  = n[7] & ((|n[6:0]) | n[8]);
    sum  = {1'b0, n[31:8]} + {24'd0, inc};
    frac = sum[24] ? 23'd0 : sum[22:0];
    expo = 8'd158 - {3'd0, lz} - {3'd0, k} + {7'd0, sum[24]};

    if (cfg.is_float) begin
      fbits = (raw[30:23] == 8'hFF) ? 32'd0 : raw;
    end else if (n[31] == 1'b0) begin
      fbits = 32'd0;
    end else begin
      fbits = {neg, expo, frac};
    end
  end

endmodule

### test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the PCM sample to float32 converter in every encoding. A local
// predictor works out each float pattern from the raw word and the current
// register settings; every result is compared with the oldest pending one.
// ----------------------------------------------------------------------------
module tb
  import pcm2f_pkg::*;
();

  localparam int CYCLE_LIMIT = 300000;
  localparam int LATENCY     = 2;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [31:0] in_raw_sample = '0;
  logic        out_strobe;
  logic [31:0] out_float_sample;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  pcm2f_cfg_t  cur_cfg;
  logic [31:0] pending_floats[$];
  int          fail_count = 0;
  int          cycle_count = 0;

  pcm_sample_to_float_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_raw_sample(in_raw_sample), .out_strobe(out_strobe),
    .out_float_sample(out_float_sample), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
    .pready(pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // v / 2^shift as a single, round to nearest even; results are never subnormal
  function automatic logic [31:0] scale_to_float(input logic [32:0] v, input int shift);
    logic        sgn;
    logic [32:0] mag;
    logic [32:0] keep;
    logic [32:0] rem;
    logic [32:0] half;
    int          p;
    int          sh;
    logic [7:0]  ex;
    if (v == '0) return 32'h0;
    sgn = v[32];
    mag = sgn ? -v : v;
    p = 32;
    while (!mag[p]) p--;
    if (p <= 23) begin
      keep = mag << (23 - p);
    end else begin
      sh = p - 23;
      keep = mag >> sh;
      rem = mag & ((33'd1 << sh) - 33'd1);
      half = 33'd1 << (sh - 1);
      if (rem > half || (rem == half && keep[0])) keep = keep + 33'd1;
      if (keep[24]) begin
        keep = keep >> 1;
        p++;
      end
    end
    ex = 8'(p - shift + 127);
    return {sgn, ex, keep[22:0]};
  endfunction

  function automatic logic [31:0] to_float_bits(input logic [31:0] raw);
    if (cur_cfg.is_float) begin
      if (raw[30:23] == 8'hFF) return 32'h0;
      return raw;
    end
    case (cur_cfg.width_code)
      WCODE_8:  return scale_to_float({25'd0, raw[7:0]} - 33'd128, 7);
      WCODE_16: return scale_to_float({{17{raw[15]}}, raw[15:0]}, 15);
      WCODE_24: return scale_to_float({{9{raw[23]}}, raw[23:0]}, 23);
      default:  return scale_to_float({raw[31], raw}, 31);
    endcase
  endfunction

  // accepted items: DUT updates are nonblocking, so these are pre-edge values
  always @(posedge clk) begin
    if (rst_n && start && !busy) pending_floats.push_back(to_float_bits(in_raw_sample));
  end

  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (pending_floats.size() == 0) begin
        $error("unexpected result float_sample=%h", out_float_sample);
        fail_count++;
      end else begin
        if (out_float_sample !== pending_floats[0]) begin
          $error("float_sample expected %h actual %h", pending_floats[0], out_float_sample);
          fail_count++;
        end
        void'(pending_floats.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic int pick_gap();
    if ($urandom_range(0, 9) < 5) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  task automatic send_sample(input logic [31:0] raw, input bit use_gaps);
    int gap;
    gap = use_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_raw_sample <= raw;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_floats.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_IS_FLOAT) cur_cfg.is_float = value[0];
    else cur_cfg.width_code = value[1:0];
    @(posedge clk);
  endtask

  task automatic set_mode(input logic is_float, input logic [1:0] wcode);
    drain();
    write_reg(REG_IS_FLOAT, {$urandom() & 32'hFFFF_FFFE, is_float});
    write_reg(REG_WIDTH, {$urandom() & 32'hFFFF_FFFC, wcode});
  endtask

  task automatic test_integer_extremes();
    // reset setting first: 16-bit integer
    send_sample(32'hABCD_7FFF, 0);
    send_sample(32'h1234_8000, 0);
    send_sample(32'hFFFF_0000, 0);
    send_sample(32'h0000_FFFF, 1);
    set_mode(1'b0, WCODE_8);
    send_sample(32'hFFFF_FF80, 0);
    send_sample(32'h0000_00FF, 0);
    send_sample(32'h5555_5500, 1);
    send_sample(32'h0000_007F, 0);
    set_mode(1'b0, WCODE_24);
    send_sample(32'hFF7F_FFFF, 0);
    send_sample(32'h0080_0000, 0);
    send_sample(32'hAA00_0000, 0);
    send_sample(32'h00FF_FFFF, 1);
    set_mode(1'b0, WCODE_32);
    send_sample(32'h7FFF_FFFF, 0);   // rounds up to 1.0
    send_sample(32'h8000_0000, 0);
    send_sample(32'h0000_0000, 0);
    send_sample(32'h0200_0001, 0);   // below half, truncates
    send_sample(32'h0300_0002, 0);   // tie, rounds to even
    send_sample(32'hFFFF_FFFF, 1);
  endtask

  task automatic test_float_passthrough();
    set_mode(1'b1, WCODE_8);
    send_sample(32'h7F80_0000, 0);   // +inf
    send_sample(32'hFF80_0000, 0);   // -inf
    send_sample(32'h7FC0_0001, 0);   // NaN
    send_sample(32'h8000_0000, 0);   // -0.0
    send_sample(32'h0000_0001, 0);   // subnormal
    send_sample(32'h3F80_0000, 1);
    send_sample(32'hFF7F_FFFF, 0);
  endtask

  function automatic logic [31:0] random_raw();
    logic [31:0] r;
    r = $urandom();
    case ($urandom_range(0, 7))
      0: r[30:23] = 8'hFF;
      1: r[30:23] = 8'h00;
      2: r[7:0] = {1'b1, 7'd0};            // tie-prone low bits
      3: r = $urandom_range(0, 1) ? r & 32'h0000_01FF : r | 32'hFFFF_FE00;
      default: ;
    endcase
    return r;
  endfunction

  task automatic test_random_modes();
    int n;
    for (int phase = 0; phase < 14; phase++) begin
      if (phase < 5) set_mode(1'b0, 2'(phase % 4));
      else if (phase == 5) set_mode(1'b1, WCODE_32);
      else set_mode(1'($urandom_range(0, 3) == 0), 2'($urandom_range(0, 3)));
      n = $urandom_range(60, 140);
      for (int i = 0; i < n; i++) send_sample(random_raw(), (phase % 3) != 0);
    end
  endtask

  initial begin
    cur_cfg.is_float = 1'b0;
    cur_cfg.width_code = WCODE_RESET;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_integer_extremes();
    test_float_passthrough();
    test_random_modes();
    drain();
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
